@@ design/mrkd_pkg.sv @@
// ----------------------------------------------------------------------------
// mrkd_pkg - shared types and constants of the medium-raw keycode decoder
// Holds the event record passed from the byte parser to the key map, the
// result record and the field widths and masks of the byte format.
// ----------------------------------------------------------------------------
package mrkd_pkg;

    // Byte format
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned LOW7_W      = 7;
    localparam logic [7:0]  LOW7_MASK   = 8'h7f;
    localparam logic [7:0]  TOP_BIT     = 8'h80;
    localparam int unsigned HIGH_SHIFT  = 7;

    // A three-byte report gives a 14-bit keycode
    localparam int unsigned RAW_CODE_W  = 2 * LOW7_W;

    // Result fields
    localparam int unsigned KEYCODE_W   = 10;
    localparam int unsigned S_TDATA_W   = 8;
    localparam int unsigned M_TDATA_W   = 16;

    // Key map geometry: one RAM row holds the held bits of ROW_W keys
    localparam int unsigned ROW_W       = 32;
    localparam int unsigned BIT_W       = $clog2(ROW_W);
    localparam int unsigned ROW_SEL_W   = RAW_CODE_W - BIT_W;

    localparam int unsigned NUM_KEYS_DEF = 1024;

    typedef enum logic [1:0] {
        PH_FIRST  = 2'd0,
        PH_SECOND = 2'd1,
        PH_THIRD  = 2'd2
    } phase_t;

    // Decoded key event, valid only when in range and well formed
    typedef struct packed {
        logic                  valid;
        logic                  release_key;
        logic [RAW_CODE_W-1:0] code;
    } event_t;

    // Event that leaves the key map filter
    typedef struct packed {
        logic                 valid;
        logic                 pressed;
        logic [KEYCODE_W-1:0] keycode;
    } result_t;

endpackage

@@ design/mrkd_parse.sv @@
// ----------------------------------------------------------------------------
// mrkd_parse - medium-raw report parser
// Tracks the position inside one- and three-byte reports and turns each
// completed report into a key event; malformed and out-of-range reports
// give no event.
// ----------------------------------------------------------------------------
module mrkd_parse #(
    parameter int unsigned NUM_KEYS = mrkd_pkg::NUM_KEYS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            byte_accept,
    input  logic [mrkd_pkg::BYTE_W-1:0]     raw_byte,
    output mrkd_pkg::event_t                evt
);
    import mrkd_pkg::*;

    localparam logic [RAW_CODE_W:0] KEY_LIMIT = (RAW_CODE_W+1)'(NUM_KEYS);

    phase_t              phase_reg, phase_next;
    logic                release_pending_reg, release_pending_next;
    logic [BYTE_W-1:0]   second_byte_reg, second_byte_next;

    logic [RAW_CODE_W-1:0] code_short;
    logic [RAW_CODE_W-1:0] code_long;
    logic                  short_in_range;
    logic                  long_in_range;
    logic                  long_ok;

    assign code_short = {{(RAW_CODE_W-LOW7_W){1'b0}}, raw_byte[LOW7_W-1:0]};
    assign code_long  = {second_byte_reg[LOW7_W-1:0], raw_byte[LOW7_W-1:0]};
    assign short_in_range = {1'b0, code_short} < KEY_LIMIT;
    assign long_in_range  = {1'b0, code_long} < KEY_LIMIT;
    assign long_ok = ((second_byte_reg & TOP_BIT) != '0) && ((raw_byte & TOP_BIT) != '0);

    // Next state
    always_comb begin
        phase_next           = phase_reg;
        release_pending_next = release_pending_reg;
        second_byte_next     = second_byte_reg;
        if (byte_accept) begin
            unique case (phase_reg)
                PH_SECOND: begin
                    second_byte_next = raw_byte;
                    phase_next       = PH_THIRD;
                end
                PH_THIRD: begin
                    phase_next = PH_FIRST;
                end
                default: begin
                    if ((raw_byte & LOW7_MASK) != '0) begin
                        phase_next = PH_FIRST;
                    end else begin
                        release_pending_next = raw_byte[BYTE_W-1];
                        phase_next           = PH_SECOND;
                    end
                end
            endcase
        end
    end

    // Event decode
    always_comb begin
        evt = '0;
        unique case (phase_reg)
            PH_SECOND: begin
                evt = '0;
            end
            PH_THIRD: begin
                evt.valid       = long_ok && long_in_range;
                evt.release_key = release_pending_reg;
                evt.code        = code_long;
            end
            default: begin
                evt.valid       = ((raw_byte & LOW7_MASK) != '0) && short_in_range;
                evt.release_key = raw_byte[BYTE_W-1];
                evt.code        = code_short;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg           <= PH_FIRST;
            release_pending_reg <= 1'b0;
            second_byte_reg     <= '0;
        end else begin
            phase_reg           <= phase_next;
            release_pending_reg <= release_pending_next;
            second_byte_reg     <= second_byte_next;
        end
    end

endmodule

@@ design/mrkd_keymap.sv @@
// ----------------------------------------------------------------------------
// mrkd_keymap - held-key bitmap and repeat filter
// Keeps one held bit per keycode in a RAM of ROW_W-bit rows. An event reads
// its row when accepted and writes the updated row back in the next stage;
// the row written at the accept edge is forwarded. Repeated presses of a
// held key are dropped. After reset the RAM is swept to zero.
// ----------------------------------------------------------------------------
module mrkd_keymap #(
    parameter int unsigned NUM_KEYS = mrkd_pkg::NUM_KEYS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                evt_accept,
    input  mrkd_pkg::event_t    evt,
    input  logic                out_free,
    output logic                stage_ready,
    output mrkd_pkg::result_t   res
);
    import mrkd_pkg::*;

    localparam int unsigned ROWS   = (NUM_KEYS + ROW_W - 1) / ROW_W;
    localparam int unsigned ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam logic [ROW_AW-1:0] LAST_ROW = ROW_AW'(ROWS - 1);

    logic [ROW_W-1:0] mem [ROWS];

    logic              clr_active_reg, clr_active_next;
    logic [ROW_AW-1:0] clr_row_reg, clr_row_next;

    logic              ev_valid_reg, ev_valid_next;
    event_t            ev_reg;
    logic [ROW_W-1:0]  rd_data_reg;
    logic              fwd_hit_reg;
    logic [ROW_W-1:0]  fwd_data_reg;

    logic [ROW_SEL_W-1:0] rd_row_full, ev_row_full;
    logic [ROW_AW-1:0]    rd_row, ev_row;
    logic [BIT_W-1:0]     ev_bit;
    logic [ROW_W-1:0]     row_now, bit_mask, row_upd;
    logic                 held, emit, stage2_go;
    logic                 wr_en;
    logic [ROW_AW-1:0]    wr_row;
    logic [ROW_W-1:0]     wr_data;

    assign rd_row_full = evt.code[RAW_CODE_W-1:BIT_W];
    assign rd_row      = rd_row_full[ROW_AW-1:0];
    assign ev_row_full = ev_reg.code[RAW_CODE_W-1:BIT_W];
    assign ev_row      = ev_row_full[ROW_AW-1:0];
    assign ev_bit      = ev_reg.code[BIT_W-1:0];

    // Row as it stands now, taking the write at the accept edge into account
    assign row_now  = fwd_hit_reg ? fwd_data_reg : rd_data_reg;
    assign bit_mask = ROW_W'(1) << ev_bit;
    assign held     = (row_now & bit_mask) != '0;
    assign row_upd  = ev_reg.release_key ? (row_now & ~bit_mask) : (row_now | bit_mask);

    assign emit      = ev_valid_reg && !(held && !ev_reg.release_key);
    assign stage2_go = ev_valid_reg && (!emit || out_free);

    assign wr_en   = clr_active_reg || (stage2_go && emit);
    assign wr_row  = clr_active_reg ? clr_row_reg : ev_row;
    assign wr_data = clr_active_reg ? '0 : row_upd;

    assign stage_ready = !clr_active_reg && (!ev_valid_reg || stage2_go);

    always_comb begin
        res         = '0;
        res.valid   = stage2_go && emit;
        res.pressed = !ev_reg.release_key;
        res.keycode = ev_reg.code[KEYCODE_W-1:0];
    end

    always_comb begin
        clr_active_next = clr_active_reg;
        clr_row_next    = clr_row_reg;
        if (clr_active_reg) begin
            clr_row_next = clr_row_reg + 1'b1;
            if (clr_row_reg == LAST_ROW) begin
                clr_active_next = 1'b0;
            end
        end
    end

    always_comb begin
        ev_valid_next = ev_valid_reg;
        if (evt_accept) begin
            ev_valid_next = evt.valid;
        end else if (stage2_go) begin
            ev_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_active_reg <= 1'b1;
            clr_row_reg    <= '0;
            ev_valid_reg   <= 1'b0;
        end else begin
            clr_active_reg <= clr_active_next;
            clr_row_reg    <= clr_row_next;
            ev_valid_reg   <= ev_valid_next;
        end
    end

    // Bitmap RAM: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_row] <= wr_data;
        end
        if (evt_accept) begin
            rd_data_reg <= mem[rd_row];
        end
    end

    // Capture the event and the write that races its read
    always_ff @(posedge aclk) begin
        if (evt_accept) begin
            ev_reg       <= evt;
            fwd_hit_reg  <= wr_en && (wr_row == rd_row);
            fwd_data_reg <= wr_data;
        end
    end

    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        evt_accept |-> !clr_active_reg)
        else $error("transfer accepted during bitmap clear");

    a_clear_once: assert property (@(posedge aclk) disable iff (!aresetn)
        !clr_active_reg |=> !clr_active_reg)
        else $error("bitmap clear restarted without reset");

    a_accept_has_room: assert property (@(posedge aclk) disable iff (!aresetn)
        evt_accept |-> (!ev_valid_reg || stage2_go))
        else $error("event accepted over an unfinished one");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (ev_valid_reg && !stage2_go) |=> (ev_valid_reg && $stable(ev_reg)))
        else $error("stalled event lost or changed");

    a_repeat_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (ev_valid_reg && held && !ev_reg.release_key) |-> !res.valid)
        else $error("repeated press of a held key emitted");

endmodule

@@ design/medium_raw_keycode_decoder_top.sv @@
// ----------------------------------------------------------------------------
// medium_raw_keycode_decoder_top - medium-raw keyboard byte decoder
// Takes one raw keyboard byte per transfer and emits press and release
// events with held-key filtering.
// ----------------------------------------------------------------------------
// One byte is taken per clock cycle when the output is free. A result passes
// from the transfer of the byte completing its report into the event stage,
// then through the bitmap read-modify-write into the output register. The
// throughput is set by the single read-modify-write of the held-key bitmap
// RAM, with the row written as an event is accepted forwarded to that event.
// After reset the bitmap is swept to zero, one 32-key row per cycle, while
// s_tready stays low. Malformed three-byte reports, keycodes at or above
// NUM_KEYS and repeated presses of a held key give no result.
module medium_raw_keycode_decoder_top #(
    parameter int unsigned NUM_KEYS = mrkd_pkg::NUM_KEYS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [mrkd_pkg::S_TDATA_W-1:0]   s_tdata,   // [7:0] raw_byte
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [mrkd_pkg::M_TDATA_W-1:0]   m_tdata,   // [9:0] keycode, rest zero
    output logic                             m_tuser    // [0] pressed
);
    import mrkd_pkg::*;

    logic     s_accept;
    logic     stage_ready;
    logic     out_free;
    event_t   evt;
    result_t  res;

    logic                  m_tvalid_reg, m_tvalid_next;
    logic [KEYCODE_W-1:0]  keycode_reg;
    logic                  pressed_reg;

    assign s_tready = stage_ready;
    assign s_accept = s_tvalid && stage_ready;
    assign out_free = !m_tvalid_reg || m_tready;

    mrkd_parse #(
        .NUM_KEYS (NUM_KEYS)
    ) u_parse (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .byte_accept (s_accept),
        .raw_byte    (s_tdata[BYTE_W-1:0]),
        .evt         (evt)
    );

    mrkd_keymap #(
        .NUM_KEYS (NUM_KEYS)
    ) u_keymap (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .evt_accept  (s_accept),
        .evt         (evt),
        .out_free    (out_free),
        .stage_ready (stage_ready),
        .res         (res)
    );

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (res.valid) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res.valid) begin
            keycode_reg <= res.keycode;
            pressed_reg <= res.pressed;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_W-KEYCODE_W){1'b0}}, keycode_reg};
    assign m_tuser  = pressed_reg;

endmodule

@@ tb/sv/tb_medium_raw_keycode_decoder_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_medium_raw_keycode_decoder_top - self-checking bench of the keycode decoder
// Drives medium-raw keyboard bytes into the decoder, predicts each press and
// release event with a local model of the report parser and held-key map, and
// compares every result transfer field by field. A directed table comes first,
// then random well-formed reports mixed with broken reports and noise bytes,
// with random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_medium_raw_keycode_decoder_top;

    import mrkd_pkg::*;

    localparam int unsigned NUM_KEYS    = NUM_KEYS_DEF;
    localparam int unsigned TOTAL_BYTES = 1450;
    localparam int unsigned NUM_ROWS    = 24;

    typedef struct packed {
        logic [KEYCODE_W-1:0] keycode;
        logic                 pressed;
    } key_event_t;

    // One directed byte; when fixed is set, the expected outcome is typed in
    typedef struct packed {
        logic [7:0]           raw;
        bit                   fixed;
        bit                   has_event;
        logic [KEYCODE_W-1:0] keycode;
        logic                 pressed;
    } byte_row_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;

    // Decoder state as seen by the predictor
    phase_t               parse_phase;
    logic                 release_latched;
    logic [7:0]           second_latched;
    bit                   key_held [NUM_KEYS];

    key_event_t           pending_events [$];
    int unsigned          error_count;
    int unsigned          bytes_sent;
    bit                   calm;

    byte_row_t directed_rows [NUM_ROWS] = '{
        '{8'h01, 1'b1, 1'b1, 10'd1,    1'b1},  // press of key 1
        '{8'h01, 1'b1, 1'b0, 10'd0,    1'b0},  // repeated press, dropped
        '{8'h81, 1'b1, 1'b1, 10'd1,    1'b0},  // release of key 1
        '{8'h85, 1'b1, 1'b1, 10'd5,    1'b0},  // release of a key not held
        '{8'h7f, 1'b1, 1'b1, 10'd127,  1'b1},
        '{8'hff, 1'b1, 1'b1, 10'd127,  1'b0},
        '{8'h00, 1'b0, 1'b0, 10'd0,    1'b0},  // three-byte press of key zero
        '{8'h80, 1'b0, 1'b0, 10'd0,    1'b0},
        '{8'h80, 1'b1, 1'b1, 10'd0,    1'b1},
        '{8'h00, 1'b0, 1'b0, 10'd0,    1'b0},  // three-byte press of top key
        '{8'h87, 1'b0, 1'b0, 10'd0,    1'b0},
        '{8'hff, 1'b1, 1'b1, 10'd1023, 1'b1},
        '{8'h80, 1'b0, 1'b0, 10'd0,    1'b0},  // three-byte release of top key
        '{8'h87, 1'b0, 1'b0, 10'd0,    1'b0},
        '{8'hff, 1'b1, 1'b1, 10'd1023, 1'b0},
        '{8'h00, 1'b0, 1'b0, 10'd0,    1'b0},  // keycode just out of range
        '{8'h88, 1'b0, 1'b0, 10'd0,    1'b0},
        '{8'h80, 1'b1, 1'b0, 10'd0,    1'b0},
        '{8'h00, 1'b0, 1'b0, 10'd0,    1'b0},  // second byte without top bit
        '{8'h05, 1'b0, 1'b0, 10'd0,    1'b0},
        '{8'h85, 1'b1, 1'b0, 10'd0,    1'b0},
        '{8'h80, 1'b0, 1'b0, 10'd0,    1'b0},  // third byte without top bit
        '{8'h81, 1'b0, 1'b0, 10'd0,    1'b0},
        '{8'h01, 1'b1, 1'b0, 10'd0,    1'b0}
    };

    medium_raw_keycode_decoder_top #(
        .NUM_KEYS (NUM_KEYS)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #400000;
        $display("medium_raw_keycode_decoder_top test failed");
        $finish;
    end

    // Filter one decoded keycode through the held-key map
    function automatic void filter_key(input logic [RAW_CODE_W-1:0] code,
                                       input logic release_key,
                                       output bit has_event, output key_event_t ev);
        has_event = 1'b0;
        ev        = '0;
        if (code < NUM_KEYS && !(!release_key && key_held[code])) begin
            key_held[code] = !release_key;
            has_event      = 1'b1;
            ev.keycode     = code[KEYCODE_W-1:0];
            ev.pressed     = !release_key;
        end
    endfunction

    function automatic void decode_raw_byte(input logic [7:0] raw, output bit has_event,
                                            output key_event_t ev);
        logic [RAW_CODE_W-1:0] code;
        has_event = 1'b0;
        ev        = '0;
        case (parse_phase)
            PH_SECOND: begin
                second_latched = raw;
                parse_phase    = PH_THIRD;
            end
            PH_THIRD: begin
                parse_phase = PH_FIRST;
                if ((second_latched & TOP_BIT) != 0 && (raw & TOP_BIT) != 0) begin
                    code = (RAW_CODE_W'(second_latched & LOW7_MASK) << HIGH_SHIFT)
                         | RAW_CODE_W'(raw & LOW7_MASK);
                    filter_key(code, release_latched, has_event, ev);
                end
            end
            default: begin
                parse_phase = PH_FIRST;
                if ((raw & LOW7_MASK) != 0) begin
                    filter_key(RAW_CODE_W'(raw & LOW7_MASK), (raw & TOP_BIT) != 0,
                               has_event, ev);
                end else begin
                    // open a three-byte report
                    release_latched = (raw & TOP_BIT) != 0;
                    parse_phase     = PH_SECOND;
                end
            end
        endcase
    endfunction

    // Offer one byte from a falling edge; return at the falling edge after its transfer
    task automatic send_raw(input logic [7:0] raw, input byte_row_t row);
        bit         has_event;
        key_event_t ev;
        while (!calm && $urandom_range(0, 99) < 6) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= raw;
        do @(posedge aclk); while (!s_tready);
        decode_raw_byte(raw, has_event, ev);
        if (row.fixed) begin
            has_event  = row.has_event;
            ev.keycode = row.keycode;
            ev.pressed = row.pressed;
        end
        if (has_event)
            pending_events.push_back(ev);
        bytes_sent++;
        calm = bytes_sent >= 500 && bytes_sent < 800;
        @(negedge aclk);
    endtask

    task automatic send_random(input logic [7:0] raw);
        send_raw(raw, '0);
    endtask

    // Result side: stall at random, check each transfer against the oldest event
    always @(negedge aclk) begin
        if (aresetn)
            m_tready <= calm || $urandom_range(0, 99) >= 6;
    end

    always @(posedge aclk) begin
        key_event_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_events.size() == 0) begin
                $error("unexpected result: keycode %0d pressed %0b", m_tdata[KEYCODE_W-1:0],
                       m_tuser);
                error_count++;
            end else begin
                want = pending_events.pop_front();
                if (m_tdata[KEYCODE_W-1:0] !== want.keycode) begin
                    $error("keycode: expected %0d, actual %0d", want.keycode,
                           m_tdata[KEYCODE_W-1:0]);
                    error_count++;
                end
                if (m_tuser !== want.pressed) begin
                    $error("pressed: expected %0b, actual %0b", want.pressed, m_tuser);
                    error_count++;
                end
                if (m_tdata[M_TDATA_W-1:KEYCODE_W] !== '0) begin
                    $error("tdata padding: expected 0, actual %0h",
                           m_tdata[M_TDATA_W-1:KEYCODE_W]);
                    error_count++;
                end
            end
        end
    end

    initial begin
        int unsigned kind;
        logic [7:0]  first_b;
        logic [7:0]  second_b;
        logic [7:0]  third_b;
        logic [6:0]  low7;

        aresetn         = 1'b0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        m_tready        = 1'b0;
        error_count     = 0;
        bytes_sent      = 0;
        calm            = 1'b0;
        parse_phase     = PH_FIRST;
        release_latched = 1'b0;
        second_latched  = '0;
        foreach (key_held[i])
            key_held[i] = 1'b0;

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i])
            send_raw(directed_rows[i].raw, directed_rows[i]);

        while (bytes_sent < TOTAL_BYTES) begin
            kind = $urandom_range(0, 99);
            if (kind < 55) begin
                // single-byte report, mostly from a small key pool to provoke repeats
                low7 = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(1, 127))
                                                   : 7'($urandom_range(1, 12));
                send_random({1'($urandom_range(0, 1)), low7});
            end else if (kind < 85) begin
                first_b  = {1'($urandom_range(0, 1)), 7'd0};
                second_b = ($urandom_range(0, 99) < 85) ? {5'b10000, 3'($urandom_range(0, 7))}
                                                        : 8'($urandom_range(0, 255));
                if ($urandom_range(0, 9) == 0)
                    third_b = 8'($urandom_range(0, 255));
                else if ($urandom_range(0, 3) == 0)
                    third_b = {1'b1, 7'($urandom_range(0, 127))};
                else
                    third_b = {1'b1, 7'($urandom_range(0, 7))};
                send_random(first_b);
                send_random(second_b);
                send_random(third_b);
            end else begin
                send_random(8'($urandom_range(0, 255)));
            end
        end
        s_tvalid <= 1'b0;

        while (pending_events.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);

        if (error_count == 0)
            $display("medium_raw_keycode_decoder_top test passed");
        else
            $display("medium_raw_keycode_decoder_top test failed");
        $finish;
    end

endmodule
